// ----- rtl/ppp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the pinhole point-to-pixel projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int BASE_WIDTH  = 640;
    localparam int BASE_HEIGHT = 480;

    localparam int COORD_W  = 32;
    localparam int CFG_W    = 20;
    localparam int RATIO_W  = 14;
    localparam int LIM_W    = 14;
    localparam int POS_W    = 13;
    localparam int IDX_W    = 3;

    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(8192);

    localparam logic [IDX_W-1:0] REG_FOCAL_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRINCIPAL_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_PRINCIPAL_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE_RATIO = 3'd4;

    localparam int DIV1_STEPS = 14;
    localparam int DIV2_STEPS = 13;
    localparam int PIPE_DEPTH = DIV1_STEPS + DIV2_STEPS + 4;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        colour_word;
    } t_in;

    typedef struct packed {
        logic [10:0] pixel_col;
        logic [9:0]  pixel_row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        depth_zero;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0]   focal_x;
        logic [CFG_W-1:0]   focal_y;
        logic [CFG_W-1:0]   principal_x;
        logic [CFG_W-1:0]   principal_y;
        logic [RATIO_W-1:0] ratio;
        logic [LIM_W-1:0]   lim_w;
        logic [LIM_W-1:0]   lim_h;
    } t_cfg;

endpackage

// ----- rtl/pinhole_point_to_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_to_pixel
// Projects a colored 3D point through a pinhole camera to a clamped pixel.
// ----------------------------------------------------------------------------
// channel  | valid   | stall   | payload
// input    | i_valid | o_stall | i_data
// output   | o_valid | i_stall | o_data
// config   | i_cfg_we| -       | i_cfg_idx, i_cfg_data
// One request per cycle while the output is not stalled; each axis holds two
// bit-per-stage restoring dividers. A stalled output holds the whole pipeline,
// bubbles included; while the last stage is empty the pipeline advances.
// Reset clears the valid bits and loads the camera registers with their
// defaults.
// ----------------------------------------------------------------------------
module pinhole_point_to_pixel (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  ppp_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output ppp_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic [ppp_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [ppp_pkg::CFG_W-1:0] i_cfg_data
);
    import ppp_pkg::*;

    t_cfg             cfg;
    logic             en;
    logic [POS_W-1:0] pos_col, pos_row;
    logic             r_valid [PIPE_DEPTH];
    logic             r_zero  [PIPE_DEPTH];
    logic [23:0]      r_rgb   [PIPE_DEPTH];

    ppp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign en      = !r_valid[PIPE_DEPTH-1] || !i_stall;
    assign o_stall = !en;

    ppp_axis u_col (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p   (i_data.point_x),
        .i_z   (i_data.point_z),
        .i_f   (cfg.focal_x),
        .i_c   (cfg.principal_x),
        .i_r   (cfg.ratio),
        .i_lim (cfg.lim_w),
        .o_pos (pos_col)
    );

    ppp_axis u_row (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p   (i_data.point_y),
        .i_z   (i_data.point_z),
        .i_f   (cfg.focal_y),
        .i_c   (cfg.principal_y),
        .i_r   (cfg.ratio),
        .i_lim (cfg.lim_h),
        .o_pos (pos_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= (i_data.point_z == 32'sd0);
            r_rgb[0]  <= i_data.colour_word;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_rgb[k]  <= r_rgb[k-1];
            end
        end
    end

    assign o_valid           = r_valid[PIPE_DEPTH-1];
    assign o_data.pixel_col  = r_zero[PIPE_DEPTH-1] ? 11'd0 : 11'(pos_col);
    assign o_data.pixel_row  = r_zero[PIPE_DEPTH-1] ? 10'd0 : 10'(pos_row);
    assign o_data.red        = r_rgb[PIPE_DEPTH-1][23:16];
    assign o_data.green      = r_rgb[PIPE_DEPTH-1][15:8];
    assign o_data.blue       = r_rgb[PIPE_DEPTH-1][7:0];
    assign o_data.depth_zero = r_zero[PIPE_DEPTH-1];

`ifndef SYNTHESIS
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_valid[0])
        else $error("accepted request did not enter the pipeline");
    a_zero_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.depth_zero) |-> (o_data.pixel_col == 11'd0 &&
        o_data.pixel_row == 10'd0))
        else $error("zero depth result has a nonzero position");
    a_col_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.lim_w != '0) |-> (LIM_W'(pos_col) < cfg.lim_w))
        else $error("column outside image width");
    a_row_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.lim_h != '0) |-> (LIM_W'(pos_row) < cfg.lim_h))
        else $error("row outside image height");
`endif

endmodule

// ----- rtl/ppp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_cfg
// Camera registers, the clamped scale and the derived image size.
// ----------------------------------------------------------------------------
module ppp_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ppp_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [ppp_pkg::CFG_W-1:0] i_cfg_data,
    output ppp_pkg::t_cfg             o_cfg
);
    import ppp_pkg::*;

    logic [CFG_W-1:0]   r_fx, r_fy, r_cx, r_cy;
    logic [RATIO_W-1:0] r_ratio;
    logic [RATIO_W-1:0] n_ratio_sat;
    logic [27:0]        n_prod_w, n_prod_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx    <= CFG_W'(138040);
            r_fy    <= CFG_W'(138028);
            r_cx    <= CFG_W'(81167);
            r_cy    <= CFG_W'(59587);
            r_ratio <= RATIO_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FOCAL_X:     r_fx    <= i_cfg_data;
                REG_FOCAL_Y:     r_fy    <= i_cfg_data;
                REG_PRINCIPAL_X: r_cx    <= i_cfg_data;
                REG_PRINCIPAL_Y: r_cy    <= i_cfg_data;
                REG_SCALE_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_ratio_sat = (r_ratio > RATIO_MAX) ? RATIO_MAX : r_ratio;
    assign n_prod_w    = 28'(BASE_WIDTH) * 28'(n_ratio_sat);
    assign n_prod_h    = 28'(BASE_HEIGHT) * 28'(n_ratio_sat);

    assign o_cfg.focal_x     = r_fx;
    assign o_cfg.focal_y     = r_fy;
    assign o_cfg.principal_x = r_cx;
    assign o_cfg.principal_y = r_cy;
    assign o_cfg.ratio       = n_ratio_sat;
    assign o_cfg.lim_w       = n_prod_w[12 +: LIM_W];
    assign o_cfg.lim_h       = n_prod_h[12 +: LIM_W];

endmodule

// ----- rtl/ppp_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_axis
// One image axis: products, sum, two restoring dividers and final rounding
// and clamping, one register stage per step.
// ----------------------------------------------------------------------------
module ppp_axis (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [31:0]          i_p,
    input  logic signed [31:0]          i_z,
    input  logic [ppp_pkg::CFG_W-1:0]   i_f,
    input  logic [ppp_pkg::CFG_W-1:0]   i_c,
    input  logic [ppp_pkg::RATIO_W-1:0] i_r,
    input  logic [ppp_pkg::LIM_W-1:0]   i_lim,
    output logic [ppp_pkg::POS_W-1:0]   o_pos
);
    import ppp_pkg::*;

    logic signed [52:0] r_pf, r_cz, n_pf, n_cz, n_sum;
    logic               r_zneg;
    logic [31:0]        r_az;

    assign n_pf = 53'(i_p) * 53'($signed({1'b0, i_f}));
    assign n_cz = 53'($signed({1'b0, i_c})) * 53'(i_z);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pf   <= n_pf;
            r_cz   <= n_cz;
            r_zneg <= i_z[31];
            r_az   <= i_z[31] ? 32'(-i_z) : 32'(i_z);
        end
    end

    logic [51:0] r_rem1 [DIV1_STEPS+1];
    logic [51:0] r_d1   [DIV1_STEPS+1];
    logic [13:0] r_q1   [DIV1_STEPS+1];
    logic        r_neg1 [DIV1_STEPS+1];

    assign n_sum = r_pf + r_cz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem1[0] <= n_sum[52] ? 52'(-n_sum) : 52'(n_sum);
            r_d1[0]   <= {r_az, 20'b0};
            r_q1[0]   <= '0;
            r_neg1[0] <= n_sum[52] ^ r_zneg;
        end
    end

    for (genvar j = 1; j <= DIV1_STEPS; j++) begin : g_div1
        logic [65:0] n_sh;
        logic        n_ge;
        assign n_sh = {14'b0, r_d1[j-1]} << (DIV1_STEPS - j);
        assign n_ge = {14'b0, r_rem1[j-1]} >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem1[j] <= n_ge ? 52'({14'b0, r_rem1[j-1]} - n_sh) : r_rem1[j-1];
                r_d1[j]   <= r_d1[j-1];
                r_q1[j]   <= {r_q1[j-1][12:0], n_ge};
                r_neg1[j] <= r_neg1[j-1];
            end
        end
    end

    logic [63:0] r_rem2 [DIV2_STEPS+1];
    logic [51:0] r_d2   [DIV2_STEPS+1];
    logic [12:0] r_q2   [DIV2_STEPS+1];
    logic [26:0] r_q1r  [DIV2_STEPS+1];
    logic        r_neg2 [DIV2_STEPS+1];
    logic        r_sat2 [DIV2_STEPS+1];
    logic [65:0] n_prod;

    assign n_prod = 66'(r_rem1[DIV1_STEPS]) * 66'(i_r);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem2[0] <= n_prod[63:0];
            r_d2[0]   <= r_d1[DIV1_STEPS];
            r_q2[0]   <= '0;
            r_q1r[0]  <= 27'(r_q1[DIV1_STEPS][12:0]) * 27'(i_r);
            r_neg2[0] <= r_neg1[DIV1_STEPS];
            r_sat2[0] <= r_q1[DIV1_STEPS][13];
        end
    end

    for (genvar j = 1; j <= DIV2_STEPS; j++) begin : g_div2
        logic [65:0] n_sh;
        logic        n_ge;
        assign n_sh = {14'b0, r_d2[j-1]} << (DIV2_STEPS - j);
        assign n_ge = {2'b0, r_rem2[j-1]} >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem2[j] <= n_ge ? 64'({2'b0, r_rem2[j-1]} - n_sh) : r_rem2[j-1];
                r_d2[j]   <= r_d2[j-1];
                r_q2[j]   <= {r_q2[j-1][11:0], n_ge};
                r_q1r[j]  <= r_q1r[j-1];
                r_neg2[j] <= r_neg2[j-1];
                r_sat2[j] <= r_sat2[j-1];
            end
        end
    end

    logic        n_round;
    logic [27:0] n_q;
    logic [POS_W-1:0] n_pos, r_pos;

    assign n_round = {r_rem2[DIV2_STEPS], 1'b0} >= {13'b0, r_d2[DIV2_STEPS]};
    assign n_q     = 28'(r_q1r[DIV2_STEPS]) + 28'(r_q2[DIV2_STEPS]) + 28'(n_round);

    always_comb begin
        if (i_lim == '0 || r_neg2[DIV2_STEPS]) begin
            n_pos = '0;
        end else if (r_sat2[DIV2_STEPS] || n_q >= 28'(i_lim)) begin
            n_pos = POS_W'(i_lim - LIM_W'(1));
        end else begin
            n_pos = n_q[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

// ----- dv/pinhole_point_to_pixel_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_to_pixel_tb
// Streams points through the projector under several camera settings and
// compares each pixel request against an exact rational projection.
// ----------------------------------------------------------------------------
module pinhole_point_to_pixel_tb;
    import ppp_pkg::*;

    localparam int  LATENCY   = PIPE_DEPTH + 8;
    localparam longint CYCLE_LIMIT = 600000;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_data = '0;
    logic                 blk_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_we = 1'b0;
    logic [IDX_W-1:0]     cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic [CFG_W-1:0]     cam_fx, cam_fy, cam_cx, cam_cy;
    logic [RATIO_W-1:0]   cam_ratio;

    t_in                  point_queue[$];
    t_out                 pixel_queue[$];
    logic                 in_taken = 1'b0;
    int                   gap_left = 0;
    int                   stall_left = 0;
    bit                   idle_on = 1'b1;
    int                   hold_asks = 0;
    int                   hold_seen = 0;
    int                   errors = 0;
    int                   n_points = 0;
    int                   n_pixels = 0;
    int                   n_phases = 0;
    longint               cycles = 0;

    pinhole_point_to_pixel u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (blk_stall),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_data     (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] axis_pos(longint p, longint z, longint f, longint c,
                                             longint r, longint lim);
        longint       n;
        bit           neg;
        logic [127:0] an, az, d, q1, r1, prod, q, rem;
        n    = p * f + c * z;
        neg  = (n < 0) != (z < 0);
        an   = (n < 0) ? 128'(-n) : 128'(n);
        az   = (z < 0) ? 128'(-z) : 128'(z);
        d    = az << 20;
        q1   = an / d;
        r1   = an % d;
        prod = r1 * 128'(r);
        q    = q1 * 128'(r) + prod / d;
        rem  = prod % d;
        if (2 * rem >= d) q = q + 1;
        if (lim == 0) return 64'd0;
        if (neg && q != 0) return 64'd0;
        if (q >= 128'(lim)) return 64'(lim - 1);
        return q[63:0];
    endfunction

    function automatic t_out project_point(t_in pt);
        t_out        o;
        longint      r, img_w, img_h;
        logic [63:0] col, row;
        r     = (cam_ratio > 14'd8192) ? 8192 : longint'(cam_ratio);
        img_w = (BASE_WIDTH * r) >>> 12;
        img_h = (BASE_HEIGHT * r) >>> 12;
        col   = 0;
        row   = 0;
        o.depth_zero = (pt.point_z == 0);
        if (pt.point_z != 0) begin
            col = axis_pos(pt.point_x, pt.point_z, cam_fx, cam_cx, r, img_w);
            row = axis_pos(pt.point_y, pt.point_z, cam_fy, cam_cy, r, img_h);
        end
        o.pixel_col = col[10:0];
        o.pixel_row = row[9:0];
        o.red   = pt.colour_word[23:16];
        o.green = pt.colour_word[15:8];
        o.blue  = pt.colour_word[7:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (!idle_on || k < 65) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: a new request is offered once the current one has been taken.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (point_queue.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= point_queue.pop_front();
                gap_left = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d pixels outstanding", $realtime, pixel_queue.size());
            $display("pinhole_point_to_pixel_tb: FAIL");
            $finish;
        end
        in_taken <= in_valid && !blk_stall;
        if (rst_n && in_valid && !blk_stall) begin
            pixel_queue = {pixel_queue, project_point(in_data)};
            n_points = n_points + 1;
        end
    end

    always @(posedge clk) begin
        t_out e;
        if (rst_n && out_valid && !out_stall) begin
            n_pixels = n_pixels + 1;
            if (pixel_queue.size() == 0) begin
                $display("%0t unexpected request, actual %h", $realtime, out_data);
                errors = errors + 1;
            end else begin
                e = pixel_queue.pop_front();
                if (out_data.pixel_col !== e.pixel_col || out_data.pixel_row !== e.pixel_row ||
                    out_data.red !== e.red || out_data.green !== e.green ||
                    out_data.blue !== e.blue || out_data.depth_zero !== e.depth_zero) begin
                    $display("%0t mismatch: expected col %0d row %0d rgb %h%h%h z0 %b",
                             $realtime, e.pixel_col, e.pixel_row, e.red, e.green, e.blue,
                             e.depth_zero);
                    $display("%0t           actual col %0d row %0d rgb %h%h%h z0 %b",
                             $realtime, out_data.pixel_col, out_data.pixel_row, out_data.red,
                             out_data.green, out_data.blue, out_data.depth_zero);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_FOCAL_X:     cam_fx = val;
            REG_FOCAL_Y:     cam_fy = val;
            REG_PRINCIPAL_X: cam_cx = val;
            REG_PRINCIPAL_Y: cam_cy = val;
            REG_SCALE_RATIO: cam_ratio = val[RATIO_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_camera(logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy,
                              logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                              logic [CFG_W-1:0] ratio);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_PRINCIPAL_X, cx);
        write_reg(REG_PRINCIPAL_Y, cy);
        write_reg(REG_SCALE_RATIO, ratio);
    endtask

    task automatic drain();
        wait (point_queue.size() == 0 && !in_valid && pixel_queue.size() == 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic t_in make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [23:0] c);
        t_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        p.colour_word = c;
        return p;
    endfunction

    function automatic t_in random_point();
        int     k;
        longint z;
        k = $urandom_range(0, 99);
        if (k < 20)
            return make_point($urandom, $urandom, $urandom, 24'($urandom));
        if (k < 25)
            return make_point($urandom, $urandom, 32'd0, 24'($urandom));
        if (k < 35)
            z = $urandom_range(1, 64) * (($urandom & 1) ? 1 : -1);
        else
            z = $urandom_range(19660, 655360);
        return make_point(32'($urandom_range(0, 2 * z[30:0]) - z[30:0] / 2 * 2),
                          32'($urandom_range(0, 2 * z[30:0]) - z[30:0] / 2 * 2),
                          32'(z), 24'($urandom));
    endfunction

    task automatic run_phase(int count, bit squeeze);
        for (int i = 0; i < count; i++) begin
            point_queue = {point_queue, random_point()};
            if (squeeze && i == count / 3) begin
                hold_asks = hold_asks + 1;
            end
        end
        drain();
        n_phases = n_phases + 1;
    endtask

    initial begin
        cam_fx    = 20'd138040;
        cam_fy    = 20'd138028;
        cam_cx    = 20'd81167;
        cam_cy    = 20'd59587;
        cam_ratio = 14'd4096;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // Directed points under the reset camera.
        point_queue = {point_queue, make_point(32'd0, 32'd0, 32'd0, 24'hffffff)};
        point_queue = {point_queue,
                       make_point(32'h7fffffff, 32'h7fffffff, 32'd0, 24'h000000)};
        point_queue = {point_queue, make_point(32'd0, 32'd0, 32'h00010000, 24'h123456)};
        point_queue = {point_queue,
                       make_point(32'h80000000, 32'h80000000, 32'd1, 24'hff00ff)};
        point_queue = {point_queue,
                       make_point(32'h7fffffff, 32'h7fffffff, 32'd1, 24'h00ff00)};
        point_queue = {point_queue,
                       make_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 24'hab)};
        point_queue = {point_queue,
                       make_point(32'd5, 32'hfffffffb, 32'h80000000, 24'hcd0000)};
        point_queue = {point_queue,
                       make_point(32'h00008000, 32'hffff8000, 32'h7fffffff, 24'h5a5a5a)};
        point_queue = {point_queue,
                       make_point(32'hfff00000, 32'h00100000, 32'h00010000, 24'ha5a5a5)};
        point_queue = {point_queue,
                       make_point(32'h00010000, 32'h00010000, 32'hffff0000, 24'h010203)};
        point_queue = {point_queue,
                       make_point(32'hffff8000, 32'h00008000, 32'h00020000, 24'h800000)};
        point_queue = {point_queue,
                       make_point(32'h80000000, 32'h7fffffff, 32'h80000000, 24'h7fffff)};
        drain();
        run_phase(200, 1'b1);

        idle_on = 1'b0;
        set_camera(20'd0, 20'd0, 20'd0, 20'd0, 20'd8192);
        write_reg(REG_SPARE_LO, 20'hfffff);
        write_reg(REG_SPARE_HI, 20'h12345);
        run_phase(120, 1'b0);
        idle_on = 1'b1;

        set_camera(20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'h3fff);
        run_phase(150, 1'b0);
        set_camera(20'd1000, 20'd1200, 20'd40000, 20'd30000, 20'd1);
        run_phase(100, 1'b0);
        set_camera(20'd90000, 20'd85000, 20'd70000, 20'd50000, 20'd0);
        run_phase(80, 1'b0);
        for (int ph = 0; ph < 4; ph++) begin
            set_camera(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                       20'($urandom_range(1, 9000)));
            run_phase(140, ph == 2);
        end

        wait (pixel_queue.size() == 0);
        repeat (LATENCY) @(posedge clk);
        $display("Covered %0d points and %0d pixel requests over %0d camera settings,",
                 n_points, n_pixels, n_phases);
        $display("including zero depth, clamped edges, empty images and a long output hold.");
        if (errors == 0 && pixel_queue.size() == 0) begin
            $display("pinhole_point_to_pixel_tb: PASS");
        end else begin
            $display("pinhole_point_to_pixel_tb: FAIL");
        end
        $finish;
    end
endmodule
